// ===== design/tbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_pkg: shared types and constants for the 256-bit tweakable block cipher
// Word and stage types, pipeline depth and the MIX rotation schedule.
// ----------------------------------------------------------------------------
package tbc_pkg;

	localparam int NUM_ROUNDS = 72;
	localparam logic [63:0] KEY_PARITY = 64'h1bd11bdaa9fc1a22;

	// Subkey index counts up to NUM_ROUNDS / 4.
	localparam int SK_IDX_W = $clog2(NUM_ROUNDS / 4 + 1);

	// Stage 0 expands the key; one stage per round; one injection stage
	// before every fourth round and one after the last round.
	localparam int PIPE_LAST = (NUM_ROUNDS - 1) + (NUM_ROUNDS - 1) / 4 + 3;

	typedef logic [63:0] word_t;

	typedef struct packed {
		word_t [3:0] v;
		word_t [4:0] kw;
		word_t [2:0] tw;
		word_t [3:0] sk;
	} stage_t;

	// Which key and tweak words form the next subkey, and its index.
	typedef struct packed {
		logic [2:0]          k0;
		logic [2:0]          k1;
		logic [2:0]          k2;
		logic [2:0]          k3;
		logic [1:0]          t0;
		logic [1:0]          t1;
		logic [SK_IDX_W-1:0] idx;
	} sk_sel_t;

	function automatic logic [5:0] rot_amt(input logic [2:0] r, input logic j);
		logic [5:0] amt;
		case ({r, j})
			4'd0:    amt = 6'd14;
			4'd1:    amt = 6'd16;
			4'd2:    amt = 6'd52;
			4'd3:    amt = 6'd57;
			4'd4:    amt = 6'd23;
			4'd5:    amt = 6'd40;
			4'd6:    amt = 6'd5;
			4'd7:    amt = 6'd37;
			4'd8:    amt = 6'd25;
			4'd9:    amt = 6'd33;
			4'd10:   amt = 6'd46;
			4'd11:   amt = 6'd12;
			4'd12:   amt = 6'd58;
			4'd13:   amt = 6'd22;
			4'd14:   amt = 6'd32;
			4'd15:   amt = 6'd32;
			default: amt = 6'd0;
		endcase
		return amt;
	endfunction

endpackage

// ===== design/tbc_expand.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_expand: key and tweak expansion stage
// Derives the fifth key word, the third tweak word and subkey zero.
// ----------------------------------------------------------------------------
module tbc_expand
	import tbc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  word_t [3:0]     plain,
	input  word_t [3:0]     key,
	input  word_t [1:0]     tweak,
	output logic            out_valid,
	output stage_t          out_stage
);

	logic   valid_s1;
	stage_t stage_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		stage_s1.v     <= plain;
		stage_s1.kw    <= {key[0] ^ key[1] ^ key[2] ^ key[3] ^ KEY_PARITY, key};
		stage_s1.tw    <= {tweak[0] ^ tweak[1], tweak};
		// subkey zero: k0, k1 + t0, k2 + t1, k3 + 0
		stage_s1.sk[0] <= key[0];
		stage_s1.sk[1] <= key[1] + tweak[0];
		stage_s1.sk[2] <= key[2] + tweak[1];
		stage_s1.sk[3] <= key[3];
	end

	assign out_valid = valid_s1;
	assign out_stage = stage_s1;

endmodule

// ===== design/tbc_inject.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_inject: subkey injection stage
// Adds the precomputed subkey into the four state words.
// ----------------------------------------------------------------------------
module tbc_inject
	import tbc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  stage_t in_stage,
	output logic   out_valid,
	output stage_t out_stage
);

	logic   valid_s1;
	stage_t stage_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			stage_s1.v[i] <= in_stage.v[i] + in_stage.sk[i];
		end
		stage_s1.kw <= in_stage.kw;
		stage_s1.tw <= in_stage.tw;
		stage_s1.sk <= in_stage.sk;
	end

	assign out_valid = valid_s1;
	assign out_stage = stage_s1;

endmodule

// ===== design/tbc_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_round: one cipher round stage
// Two MIX operations and the word permutation; forms the next subkey alongside.
// ----------------------------------------------------------------------------
module tbc_round
	import tbc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  stage_t     in_stage,
	input  logic [5:0] rot_a,
	input  logic [5:0] rot_b,
	input  sk_sel_t    sel,
	output logic       out_valid,
	output stage_t     out_stage
);

	logic         valid_s1;
	stage_t       stage_s1;
	word_t        f0, f1, f2, f3;
	logic [127:0] rot_1, rot_3;

	always_comb begin
		rot_1 = {in_stage.v[1], in_stage.v[1]} << rot_a;
		rot_3 = {in_stage.v[3], in_stage.v[3]} << rot_b;
		f0    = in_stage.v[0] + in_stage.v[1];
		f1    = rot_1[127:64] ^ f0;
		f2    = in_stage.v[2] + in_stage.v[3];
		f3    = rot_3[127:64] ^ f2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		// permute (0,3,2,1)
		stage_s1.v     <= {f1, f2, f3, f0};
		stage_s1.kw    <= in_stage.kw;
		stage_s1.tw    <= in_stage.tw;
		stage_s1.sk[0] <= in_stage.kw[sel.k0];
		stage_s1.sk[1] <= in_stage.kw[sel.k1] + in_stage.tw[sel.t0];
		stage_s1.sk[2] <= in_stage.kw[sel.k2] + in_stage.tw[sel.t1];
		stage_s1.sk[3] <= in_stage.kw[sel.k3] + 64'(sel.idx);
	end

	assign out_valid = valid_s1;
	assign out_stage = stage_s1;

endmodule

// ===== design/tweakable_block_cipher_256_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tweakable_block_cipher_256_top: pipelined 256-bit tweakable block encryptor
// Fully unrolled round pipeline, one block per clock.
// ----------------------------------------------------------------------------
// Usage:
//   Drive plain_0..3, key_0..3 and tweak_0..1 and raise start; the block is
//   taken at the edge where start is high and busy is low. busy stays low, so
//   a new block may be presented in every cycle.
//   The ciphertext appears on cipher_0..3 with done high for exactly one
//   cycle; the receiver must take it then, it cannot hold results off.
//   Pipeline: one key expansion stage, one stage per round, and one
//   subkey injection stage before every fourth round plus one after the last.
//   Throughput: one block per cycle, set by the one-round-per-stage pipeline.
//   Reset clears all valid bits at once; blocks in flight are dropped and no
//   done pulse follows for them. Data registers are not reset.
//   Blocks are independent; nothing is kept from one transfer to the next.
// ----------------------------------------------------------------------------
module tweakable_block_cipher_256_top
	import tbc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] plain_0,
	input  logic [63:0] plain_1,
	input  logic [63:0] plain_2,
	input  logic [63:0] plain_3,
	input  logic [63:0] key_0,
	input  logic [63:0] key_1,
	input  logic [63:0] key_2,
	input  logic [63:0] key_3,
	input  logic [63:0] tweak_0,
	input  logic [63:0] tweak_1,
	output logic        done,
	output logic [63:0] cipher_0,
	output logic [63:0] cipher_1,
	output logic [63:0] cipher_2,
	output logic [63:0] cipher_3
);

	// Valid bit and payload at the output of every stage.
	logic [PIPE_LAST:0] pv;
	stage_t             pipe [PIPE_LAST+1];

	// The pipeline never stalls, so accept whenever start is raised.
	assign busy = 1'b0;

	tbc_expand u_expand (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.plain     ({plain_3, plain_2, plain_1, plain_0}),
		.key       ({key_3, key_2, key_1, key_0}),
		.tweak     ({tweak_1, tweak_0}),
		.out_valid (pv[0]),
		.out_stage (pipe[0])
	);

	// Round d sits at stage d + d/4 + 2; an injection stage precedes every
	// fourth round. Each round also forms subkey (d+1)/4; the round just
	// before an injection stage thus forms the one that stage needs.
	for (genvar d = 0; d < NUM_ROUNDS; d++) begin : g_round
		localparam int         P  = d + d / 4 + 2;
		localparam int         S  = (d + 1) / 4;
		localparam logic [2:0] RI = 3'(d % 8);
		localparam sk_sel_t SEL = '{
			k0:  3'(S % 5),
			k1:  3'((S + 1) % 5),
			k2:  3'((S + 2) % 5),
			k3:  3'((S + 3) % 5),
			t0:  2'(S % 3),
			t1:  2'((S + 1) % 3),
			idx: SK_IDX_W'(S)
		};

		if (d % 4 == 0) begin : g_inj
			tbc_inject u_inject (
				.clk       (clk),
				.arst_n    (arst_n),
				.in_valid  (pv[P-2]),
				.in_stage  (pipe[P-2]),
				.out_valid (pv[P-1]),
				.out_stage (pipe[P-1])
			);
		end

		tbc_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (pv[P-1]),
			.in_stage  (pipe[P-1]),
			.rot_a     (rot_amt(RI, 1'b0)),
			.rot_b     (rot_amt(RI, 1'b1)),
			.sel       (SEL),
			.out_valid (pv[P]),
			.out_stage (pipe[P])
		);
	end

	// Final subkey injection; its register drives the result ports directly.
	tbc_inject u_inject_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pv[PIPE_LAST-1]),
		.in_stage  (pipe[PIPE_LAST-1]),
		.out_valid (pv[PIPE_LAST]),
		.out_stage (pipe[PIPE_LAST])
	);

	assign done     = pv[PIPE_LAST];
	assign cipher_0 = pipe[PIPE_LAST].v[0];
	assign cipher_1 = pipe[PIPE_LAST].v[1];
	assign cipher_2 = pipe[PIPE_LAST].v[2];
	assign cipher_3 = pipe[PIPE_LAST].v[3];

	// A result only comes from a block that entered the pipeline in time.
	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(pv[0], PIPE_LAST))
		else $error("done without a matching transfer into the pipeline");

	// Key words travel intact: the parity word still matches at the end.
	a_key_parity: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((pipe[PIPE_LAST].kw[0] ^ pipe[PIPE_LAST].kw[1] ^
			pipe[PIPE_LAST].kw[2] ^ pipe[PIPE_LAST].kw[3] ^
			pipe[PIPE_LAST].kw[4]) == KEY_PARITY))
		else $error("key words corrupted along the pipeline");

	// Tweak words travel intact.
	a_tweak_xor: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pipe[PIPE_LAST].tw[2] == (pipe[PIPE_LAST].tw[0] ^ pipe[PIPE_LAST].tw[1])))
		else $error("tweak words corrupted along the pipeline");

endmodule
